/* sv/bed_pkg.sv */
// bed_pkg: shared types, mode codes, queue sizes, character constants and
// a hex digit helper for the backslash escape decoder. No dependencies.
`default_nettype none

package bed_pkg;

    // decoder modes
    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX1    = 3'd2,
        MODE_HEX2    = 3'd3,
        MODE_HEX2BAD = 3'd4,
        MODE_OCT     = 3'd5
    } t_mode;

    // one decoded result beat
    typedef struct packed {
        logic [7:0] byte_out;
        logic       digit_error;
        logic       run_last;
    } t_result;

    // result queue depth, pointer width and fill count width
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // input characters with a meaning of their own
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_C   = 8'h63;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_G   = 8'h67;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_7  = 8'h37;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // control codes produced by escapes
    localparam logic [7:0] CODE_BS   = 8'h08;
    localparam logic [7:0] CODE_CSI  = 8'h9B;
    localparam logic [7:0] CODE_ESC  = 8'h1B;
    localparam logic [7:0] CODE_FF   = 8'h0C;
    localparam logic [7:0] CODE_BEL  = 8'h07;
    localparam logic [7:0] CODE_LF   = 8'h0A;
    localparam logic [7:0] CODE_CR   = 8'h0D;
    localparam logic [7:0] CODE_TAB  = 8'h09;
    localparam logic [7:0] CODE_VT   = 8'h0B;

    // hex digit value: bit 4 is the valid flag, bits 3:0 the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LC_A && c <= CH_LC_F)
                     || (c >= CH_UC_A && c <= CH_UC_F)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/bed_ifs.sv */
// bed_ifs: valid/ready channel interfaces for the escape decoder input
// and result streams. Depends on nothing.
`default_nettype none

interface bed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       flush;

    modport source (output valid, output char_in, output flush, input ready);
    modport sink   (input valid, input char_in, input flush, output ready);
endinterface

interface bed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       digit_error;
    logic       run_last;

    modport source (output valid, output byte_out, output digit_error,
                    output run_last, input ready);
    modport sink   (input valid, input byte_out, input digit_error,
                    input run_last, output ready);
endinterface

`default_nettype wire

/* sv/backslash_escape_decoder.sv */
// backslash_escape_decoder: top level, decode logic and result queue.
// Depends on bed_pkg and the channel interfaces in bed_ifs.sv.
//
// Usage:
//   i_in carries one raw text byte per beat (char_in), or an end-of-text
//   marker (flush set, char_in ignored). o_out carries decoded bytes with
//   digit_error and run_last; run_last marks the final result of an input
//   beat. An input beat yields zero, one or two results.
//   Results are written into the result queue and shown on o_out from it.
//   Throughput: one input beat per cycle while the receiver keeps up and no
//   beat yields two results; the decode is one pass of logic from the mode
//   registers into a four-entry result queue, and the queue's single read
//   port delivers one result a cycle, so two results of a beat leave in turn.
//   i_in.ready is high while at least two queue entries are free, so input
//   keeps flowing while up to two finished results wait to be taken.
//   When the receiver stalls, results stay in the queue and input stops once
//   fewer than two entries are free; nothing is dropped.
//   Reset (i_rst_n low, synchronous): plain text mode, accumulator and digit
//   count cleared, queue emptied.
`default_nettype none

module backslash_escape_decoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bed_in_if.sink     i_in,
    bed_out_if.source  o_out
);
    import bed_pkg::*;

    // decoder state
    t_mode      r_mode,  n_mode;
    logic [7:0] r_accum, n_accum;
    logic [1:0] r_oleft, n_oleft;

    // result queue
    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // decode outputs
    logic [1:0] w_cnt;
    t_result    w_res0;
    t_result    w_res1;

    logic       w_in_acc;
    logic       w_out_acc;
    logic [7:0] w_low;
    logic [4:0] w_hex;
    logic       w_is_oct;
    logic [1:0] w_oleft_dec;

    // handshakes
    assign i_in.ready  = (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid = (r_count != '0);
    assign w_out_acc   = o_out.valid && o_out.ready;

    // character classes
    assign w_low = (i_in.char_in >= CH_UC_A && i_in.char_in <= CH_UC_Z)
                   ? (i_in.char_in | CASE_BIT) : i_in.char_in;
    assign w_hex       = hex_digit(i_in.char_in);
    assign w_is_oct    = (i_in.char_in >= CH_DIG_0 && i_in.char_in <= CH_DIG_7);
    assign w_oleft_dec = r_oleft - 2'd1;

    // decode: next state and up to two results
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_oleft = r_oleft;
        w_cnt   = 2'd0;
        w_res0  = '0;
        w_res1  = '0;

        if (i_in.flush) begin
            n_mode  = MODE_PLAIN;
            n_accum = 8'd0;
            n_oleft = 2'd0;
            case (r_mode)
                MODE_ESC: begin
                    w_cnt = 2'd1;
                end
                MODE_HEX1: begin
                    w_cnt              = 2'd1;
                    w_res0.digit_error = 1'b1;
                end
                MODE_HEX2, MODE_OCT: begin
                    w_cnt           = 2'd1;
                    w_res0.byte_out = r_accum;
                end
                MODE_HEX2BAD: begin
                    w_cnt              = 2'd1;
                    w_res0.byte_out    = r_accum;
                    w_res0.digit_error = 1'b1;
                end
                default: begin
                    w_cnt = 2'd0;
                end
            endcase
        end else begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode          = MODE_PLAIN;
                    w_cnt           = 2'd1;
                    w_res0.byte_out = w_low;
                    case (w_low)
                        CH_NL:   w_cnt = 2'd0;
                        CH_LC_B: w_res0.byte_out = CODE_BS;
                        CH_LC_C: w_res0.byte_out = CODE_CSI;
                        CH_LC_E: w_res0.byte_out = CODE_ESC;
                        CH_LC_F: w_res0.byte_out = CODE_FF;
                        CH_LC_G: w_res0.byte_out = CODE_BEL;
                        CH_LC_N: w_res0.byte_out = CODE_LF;
                        CH_LC_R: w_res0.byte_out = CODE_CR;
                        CH_LC_T: w_res0.byte_out = CODE_TAB;
                        CH_LC_V: w_res0.byte_out = CODE_VT;
                        CH_LC_X: begin
                            w_cnt  = 2'd0;
                            n_mode = MODE_HEX1;
                        end
                        CH_RPAREN, CH_BSLASH: begin
                            w_cnt           = 2'd2;
                            w_res0.byte_out = CH_BSLASH;
                            w_res1.byte_out = w_low;
                        end
                        default: begin
                            // octal run start
                            if (w_is_oct) begin
                                w_cnt   = 2'd0;
                                n_accum = {5'd0, w_low[2:0]};
                                n_oleft = 2'd2;
                                n_mode  = MODE_OCT;
                            end
                        end
                    endcase
                end
                MODE_HEX1: begin
                    if (w_hex[4]) begin
                        n_accum = {4'd0, w_hex[3:0]};
                        n_mode  = MODE_HEX2;
                    end else begin
                        n_accum = 8'd0;
                        n_mode  = MODE_HEX2BAD;
                    end
                end
                MODE_HEX2, MODE_HEX2BAD: begin
                    n_accum            = 8'd0;
                    w_cnt              = 2'd1;
                    w_res0.digit_error = (r_mode == MODE_HEX2BAD);
                    if (w_hex[4]) begin
                        w_res0.byte_out = {r_accum[3:0], w_hex[3:0]};
                        n_mode          = MODE_PLAIN;
                    end else begin
                        // emit the value, then treat the byte as plain text
                        w_res0.byte_out = r_accum;
                        if (i_in.char_in == CH_BSLASH) begin
                            n_mode = MODE_ESC;
                        end else begin
                            n_mode          = MODE_PLAIN;
                            w_cnt           = 2'd2;
                            w_res1.byte_out = i_in.char_in;
                        end
                    end
                end
                MODE_OCT: begin
                    if (w_is_oct) begin
                        n_accum = {r_accum[4:0], i_in.char_in[2:0]};
                        n_oleft = w_oleft_dec;
                        if (w_oleft_dec == 2'd0) begin
                            w_cnt           = 2'd1;
                            w_res0.byte_out = {r_accum[4:0], i_in.char_in[2:0]};
                            n_accum         = 8'd0;
                            n_mode          = MODE_PLAIN;
                        end
                    end else begin
                        w_cnt           = 2'd1;
                        w_res0.byte_out = r_accum;
                        n_accum         = 8'd0;
                        n_oleft         = 2'd0;
                        if (i_in.char_in == CH_BSLASH) begin
                            n_mode = MODE_ESC;
                        end else begin
                            n_mode          = MODE_PLAIN;
                            w_cnt           = 2'd2;
                            w_res1.byte_out = i_in.char_in;
                        end
                    end
                end
                default: begin
                    if (i_in.char_in == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode          = MODE_PLAIN;
                        w_cnt           = 2'd1;
                        w_res0.byte_out = i_in.char_in;
                    end
                end
            endcase
        end

        // mark the last result of the beat
        w_res0.run_last = (w_cnt == 2'd1);
        w_res1.run_last = 1'b1;
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_accum <= 8'd0;
            r_oleft <= 2'd0;
        end else if (w_in_acc) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_oleft <= n_oleft;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= w_res0;
        end
        if (w_in_acc && w_cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= w_res1;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_acc) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(w_cnt);
            end
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (w_in_acc ? CNT_W'(w_cnt) : CNT_W'(0))
                       - (w_out_acc ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // result beat
    assign o_out.byte_out    = r_mem[r_rd_ptr].byte_out;
    assign o_out.digit_error = r_mem[r_rd_ptr].digit_error;
    assign o_out.run_last    = r_mem[r_rd_ptr].run_last;

`ifndef SYNTH
    // queue never overfills
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // an octal run always has digits left
    a_oct_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_OCT |-> r_oleft != 2'd0)
        else $error("octal run with no digits left");

    // accumulator is clear outside digit runs
    a_accum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PLAIN || r_mode == MODE_ESC || r_mode == MODE_HEX1)
        |-> r_accum == 8'd0)
        else $error("stale accumulator outside digit run");

    // flush returns to plain text
    a_flush_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.flush) |=> (r_mode == MODE_PLAIN && r_oleft == 2'd0))
        else $error("flush did not return to plain mode");
`endif

endmodule

`default_nettype wire
